@@ hdl/phong_pkg.sv @@
// ----------------------------------------------------------------------------
// Phong light terms package
// Shared types, widths, register indexes and reset values for the Phong
// ambient, diffuse and specular light term pipeline.
// ----------------------------------------------------------------------------
package phong_pkg;

    // Default specular exponent.
    localparam int SHININESS_DEF = 32;

    // Port widths.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 15;
    localparam int STR_W      = 15;
    localparam int COL_W      = 8;

    // Internal widths, set by the Q2.14 input range.
    localparam int C_W       = 19;   // c = l.n in Q.14, signed
    localparam int R_W       = 21;   // reflected vector component, signed
    localparam int SQ_W      = 42;   // sum of squares and root working width
    localparam int SQ_STEPS  = 21;   // result bits of the square root
    localparam int LEN_W     = 21;   // length of the reflected vector
    localparam int DIV_STEPS = 15;   // quotient bits, quotient never exceeds 1.0
    localparam int REM_W     = 35;   // partial remainder of the division
    localparam int S_W       = 17;   // positive specular cosine
    localparam int P_W       = 37;   // power term, capped at 2^36

    localparam logic [P_W-1:0] ONE_Q14 = P_W'(16384);
    localparam logic [P_W-1:0] POW_CAP = P_W'(1) << 36;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_STRENGTH   = 4'd0,
        CFG_LIGHT_RED        = 4'd1,
        CFG_LIGHT_GREEN      = 4'd2,
        CFG_LIGHT_BLUE       = 4'd3,
        CFG_AMBIENT_STRENGTH = 4'd4,
        CFG_AMBIENT_RED      = 4'd5,
        CFG_AMBIENT_GREEN    = 4'd6,
        CFG_AMBIENT_BLUE     = 4'd7
    } t_cfg_idx;

    // Register reset values.
    localparam logic [STR_W-1:0] LIGHT_STRENGTH_RST   = 15'd16384;
    localparam logic [STR_W-1:0] AMBIENT_STRENGTH_RST = 15'd1638;
    localparam logic [COL_W-1:0] COLOUR_RST           = 8'd255;

    // One shading sample.
    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] light_dir_x;
        logic signed [15:0] light_dir_y;
        logic signed [15:0] light_dir_z;
        logic signed [15:0] eye_dir_x;
        logic signed [15:0] eye_dir_y;
        logic signed [15:0] eye_dir_z;
    } t_in;

    // One set of light terms.
    typedef struct packed {
        logic [15:0] amb_red_out;
        logic [15:0] amb_green_out;
        logic [15:0] amb_blue_out;
        logic [15:0] diff_red_out;
        logic [15:0] diff_green_out;
        logic [15:0] diff_blue_out;
        logic [15:0] spec_red_out;
        logic [15:0] spec_green_out;
        logic [15:0] spec_blue_out;
    } t_out;

    // Side data that travels with a sample through the long stages.
    typedef struct packed {
        logic [2:0][15:0]    e;      // eye direction
        logic [2:0][R_W-1:0] r;      // reflected vector
        logic                cpos;   // c above zero
        logic                lnz;    // reflected vector has nonzero length
        logic [2:0][15:0]    diff;   // finished diffuse terms
    } t_side;

    // Saturate an unsigned value to the 16-bit output range.
    function automatic logic [15:0] sat16(input logic [39:0] v);
        return (|v[39:16]) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

@@ hdl/phong_light_terms_unit.sv @@
// ----------------------------------------------------------------------------
// Phong light terms unit
// Computes the ambient, diffuse and specular RGB terms of the Phong
// reflection model for one shading sample per clock, in a fixed pipeline.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                               Direction  Transfer when
//  -------  ------------------------------------  ---------  ------------------
//  sample   i_start, o_busy, i_in                 in         i_start & !o_busy
//  result   o_valid, o_out                        out        o_valid (1 cycle)
//  config   i_cfg_valid, o_cfg_ready,             in         valid & ready
//           i_cfg_index, i_cfg_data
//
//  A sample may enter in every cycle; o_busy stays low. The depth of the
//  pipeline is set by the 21-step square root, the 15-step divider and
//  one multiplier stage per power of the specular cosine.
//  Reset clears the pipeline valid bits and loads the register defaults.
//  The result side cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module phong_light_terms_unit #(
    parameter int SHININESS = phong_pkg::SHININESS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  phong_pkg::t_in                    i_in,
    output logic                              o_valid,
    output phong_pkg::t_out                   o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [phong_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [phong_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import phong_pkg::*;

    localparam int LAT = 48 + SHININESS;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [STR_W-1:0]      r_ls;
    logic [STR_W-1:0]      r_as;
    logic [2:0][COL_W-1:0] r_lc;
    logic [2:0][COL_W-1:0] r_ac;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls <= LIGHT_STRENGTH_RST;
            r_as <= AMBIENT_STRENGTH_RST;
            r_lc <= {3{COLOUR_RST}};
            r_ac <= {3{COLOUR_RST}};
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LIGHT_STRENGTH:   r_ls    <= i_cfg_data;
                CFG_LIGHT_RED:        r_lc[0] <= i_cfg_data[COL_W-1:0];
                CFG_LIGHT_GREEN:      r_lc[1] <= i_cfg_data[COL_W-1:0];
                CFG_LIGHT_BLUE:       r_lc[2] <= i_cfg_data[COL_W-1:0];
                CFG_AMBIENT_STRENGTH: r_as    <= i_cfg_data;
                CFG_AMBIENT_RED:      r_ac[0] <= i_cfg_data[COL_W-1:0];
                CFG_AMBIENT_GREEN:    r_ac[1] <= i_cfg_data[COL_W-1:0];
                CFG_AMBIENT_BLUE:     r_ac[2] <= i_cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // Ambient terms depend on configuration only and are kept ready.
    logic [2:0][15:0] r_amb;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_amb[i] <= sat16(40'((23'(r_as) * 23'(r_ac[i])) >> 6));
        end
    end

    // ------------------------------------------------------------------
    // Valid bits travel down a shift line beside the data.
    // ------------------------------------------------------------------
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start & ~o_busy};
        end
    end

    // ------------------------------------------------------------------
    // Stage A: register the vectors and form the products of l.n.
    // ------------------------------------------------------------------
    logic signed [15:0] w_n [3];
    logic signed [15:0] w_l [3];
    logic signed [15:0] w_e [3];

    assign w_n[0] = i_in.normal_x;
    assign w_n[1] = i_in.normal_y;
    assign w_n[2] = i_in.normal_z;
    assign w_l[0] = i_in.light_dir_x;
    assign w_l[1] = i_in.light_dir_y;
    assign w_l[2] = i_in.light_dir_z;
    assign w_e[0] = i_in.eye_dir_x;
    assign w_e[1] = i_in.eye_dir_y;
    assign w_e[2] = i_in.eye_dir_z;

    logic signed [31:0] r_a_p [3];
    logic signed [15:0] r_a_n [3];
    logic signed [15:0] r_a_l [3];
    logic signed [15:0] r_a_e [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_p[i] <= w_l[i] * w_n[i];
            r_a_n[i] <= w_n[i];
            r_a_l[i] <= w_l[i];
            r_a_e[i] <= w_e[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: c = floor(l.n / 2^14).
    // ------------------------------------------------------------------
    logic signed [33:0]    w_dot;
    logic signed [C_W-1:0] r_b_c;
    logic signed [15:0]    r_b_n [3];
    logic signed [15:0]    r_b_l [3];
    logic signed [15:0]    r_b_e [3];

    assign w_dot = 34'(r_a_p[0]) + 34'(r_a_p[1]) + 34'(r_a_p[2]);

    always_ff @(posedge i_clk) begin
        r_b_c <= C_W'(w_dot >>> 14);
        for (int i = 0; i < 3; i++) begin
            r_b_n[i] <= r_a_n[i];
            r_b_l[i] <= r_a_l[i];
            r_b_e[i] <= r_a_e[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: c times n, and the positive cosine times light power.
    // ------------------------------------------------------------------
    logic [17:0]        w_cpos_val;
    logic signed [34:0] r_c_cn [3];
    logic signed [15:0] r_c_l [3];
    logic signed [15:0] r_c_e [3];
    logic [32:0]        r_c_dl;
    logic               r_c_cpos;

    assign w_cpos_val = (r_b_c > 0) ? r_b_c[17:0] : 18'd0;

    always_ff @(posedge i_clk) begin
        r_c_dl   <= 33'(w_cpos_val) * 33'(r_ls);
        r_c_cpos <= (r_b_c > 0);
        for (int i = 0; i < 3; i++) begin
            r_c_cn[i] <= 35'(r_b_c) * 35'(r_b_n[i]);
            r_c_l[i]  <= r_b_l[i];
            r_c_e[i]  <= r_b_e[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage D: reflected vector r = 2cn - l, diffuse times colour.
    // ------------------------------------------------------------------
    logic signed [R_W-1:0] r_d_r [3];
    logic [40:0]           r_d_dc [3];
    logic signed [15:0]    r_d_e [3];
    logic                  r_d_cpos;

    always_ff @(posedge i_clk) begin
        r_d_cpos <= r_c_cpos;
        for (int i = 0; i < 3; i++) begin
            r_d_r[i]  <= R_W'((r_c_cn[i] >>> 13) - 35'(r_c_l[i]));
            r_d_dc[i] <= 41'(r_c_dl) * 41'(r_lc[i]);
            r_d_e[i]  <= r_c_e[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: squares of r, finished diffuse terms.
    // ------------------------------------------------------------------
    logic signed [41:0] w_sq [3];
    logic [40:0]        r_e_sq [3];
    t_side              r_e_sd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq[i] = 42'(r_d_r[i]) * 42'(r_d_r[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_sd.cpos <= r_d_cpos;
        r_e_sd.lnz  <= 1'b0;
        for (int i = 0; i < 3; i++) begin
            r_e_sq[i]      <= w_sq[i][40:0];
            r_e_sd.r[i]    <= r_d_r[i];
            r_e_sd.e[i]    <= r_d_e[i];
            r_e_sd.diff[i] <= sat16(40'(r_d_dc[i] >> 20));
        end
    end

    // ------------------------------------------------------------------
    // Square root of the sum of squares, one result bit per stage.
    // Entry 0 holds the sum; each later entry is one step of the root.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] r_sq_v   [SQ_STEPS+1];
    logic [SQ_W-1:0] r_sq_res [SQ_STEPS+1];
    t_side           r_sq_sd  [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        r_sq_v[0]   <= SQ_W'(r_e_sq[0]) + SQ_W'(r_e_sq[1]) + SQ_W'(r_e_sq[2]);
        r_sq_res[0] <= '0;
        r_sq_sd[0]  <= r_e_sd;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [SQ_W-1:0] w_trial;

        assign w_trial = r_sq_res[k] + BIT;

        always_ff @(posedge i_clk) begin
            r_sq_sd[k+1] <= r_sq_sd[k];
            if (r_sq_v[k] >= w_trial) begin
                r_sq_v[k+1]   <= r_sq_v[k] - w_trial;
                r_sq_res[k+1] <= (r_sq_res[k] >> 1) + BIT;
            end else begin
                r_sq_v[k+1]   <= r_sq_v[k];
                r_sq_res[k+1] <= r_sq_res[k] >> 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalisation: |r| * 2^14 / len, one quotient bit per stage.
    // Entry 0 loads the dividends; the quotient never exceeds 2^14.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] w_len;
    t_side            w_dv_sd;
    logic [2:0][REM_W-1:0]     r_dv_rem [DIV_STEPS+1];
    logic [2:0][DIV_STEPS-1:0] r_dv_q   [DIV_STEPS+1];
    logic [LEN_W-1:0]          r_dv_len [DIV_STEPS+1];
    t_side                     r_dv_sd  [DIV_STEPS+1];

    assign w_len = r_sq_res[SQ_STEPS][LEN_W-1:0];

    // The side data picks up the nonzero-length flag here.
    always_comb begin
        w_dv_sd     = r_sq_sd[SQ_STEPS];
        w_dv_sd.lnz = (w_len != '0);
    end

    always_ff @(posedge i_clk) begin
        r_dv_len[0] <= w_len;
        r_dv_q[0]   <= '0;
        r_dv_sd[0]  <= w_dv_sd;
        for (int i = 0; i < 3; i++) begin
            if (r_sq_sd[SQ_STEPS].r[i][R_W-1]) begin
                r_dv_rem[0][i] <= {REM_W'(-$signed(r_sq_sd[SQ_STEPS].r[i]))} << 14;
            end else begin
                r_dv_rem[0][i] <= REM_W'(r_sq_sd[SQ_STEPS].r[i]) << 14;
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int BP = DIV_STEPS - 1 - j;
        logic [REM_W-1:0]          w_dsr;
        logic [2:0][REM_W-1:0]     w_rem;
        logic [2:0][DIV_STEPS-1:0] w_q;

        assign w_dsr = REM_W'(r_dv_len[j]) << BP;

        // One restoring step per component.
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_rem[i] = r_dv_rem[j][i];
                w_q[i]   = r_dv_q[j][i];
                if (r_dv_rem[j][i] >= w_dsr) begin
                    w_rem[i]   = r_dv_rem[j][i] - w_dsr;
                    w_q[i][BP] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_len[j+1] <= r_dv_len[j];
            r_dv_sd[j+1]  <= r_dv_sd[j];
            r_dv_rem[j+1] <= w_rem;
            r_dv_q[j+1]   <= w_q;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: signed normalised components times the eye direction.
    // ------------------------------------------------------------------
    logic signed [15:0] w_rn [3];
    logic signed [31:0] r_g_pe [3];
    t_side              r_g_sd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_sd[DIV_STEPS].r[i][R_W-1]) begin
                w_rn[i] = -$signed({1'b0, r_dv_q[DIV_STEPS][i]});
            end else begin
                w_rn[i] = $signed({1'b0, r_dv_q[DIV_STEPS][i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_sd <= r_dv_sd[DIV_STEPS];
        for (int i = 0; i < 3; i++) begin
            r_g_pe[i] <= w_rn[i] * $signed(r_dv_sd[DIV_STEPS].e[i]);
        end
    end

    // ------------------------------------------------------------------
    // Specular cosine s and the power chain, one multiply per stage.
    // Entry 0 holds s and p = 1.0; each later entry multiplies by s once.
    // ------------------------------------------------------------------
    logic signed [33:0] w_sdot;
    logic signed [17:0] w_s;
    logic               w_on;

    logic [P_W-1:0] r_pw_p  [SHININESS+1];
    logic [S_W-1:0] r_pw_s  [SHININESS+1];
    logic           r_pw_on [SHININESS+1];
    t_side          r_pw_sd [SHININESS+1];

    assign w_sdot = 34'(r_g_pe[0]) + 34'(r_g_pe[1]) + 34'(r_g_pe[2]);
    assign w_s    = 18'(w_sdot >>> 14);
    assign w_on   = r_g_sd.cpos & r_g_sd.lnz & (w_s > 0);

    always_ff @(posedge i_clk) begin
        r_pw_p[0]  <= ONE_Q14;
        r_pw_s[0]  <= w_on ? w_s[S_W-1:0] : '0;
        r_pw_on[0] <= w_on;
        r_pw_sd[0] <= r_g_sd;
    end

    for (genvar m = 0; m < SHININESS; m++) begin : g_pow
        logic [53:0] w_prod;
        logic [39:0] w_shr;

        assign w_prod = 54'(r_pw_p[m]) * 54'(r_pw_s[m]);
        assign w_shr  = w_prod[53:14];

        always_ff @(posedge i_clk) begin
            r_pw_p[m+1]  <= (w_shr > 40'(POW_CAP)) ? POW_CAP : w_shr[P_W-1:0];
            r_pw_s[m+1]  <= r_pw_s[m];
            r_pw_on[m+1] <= r_pw_on[m];
            r_pw_sd[m+1] <= r_pw_sd[m];
        end
    end

    // ------------------------------------------------------------------
    // Stages I and J: power times light strength, then times colour.
    // ------------------------------------------------------------------
    logic [51:0] r_i_ps;
    logic        r_i_on;
    t_side       r_i_sd;
    logic [59:0] r_j_psc [3];
    logic        r_j_on;
    t_side       r_j_sd;

    always_ff @(posedge i_clk) begin
        r_i_ps <= 52'(r_pw_p[SHININESS]) * 52'(r_ls);
        r_i_on <= r_pw_on[SHININESS];
        r_i_sd <= r_pw_sd[SHININESS];
        r_j_on <= r_i_on;
        r_j_sd <= r_i_sd;
        for (int i = 0; i < 3; i++) begin
            r_j_psc[i] <= 60'(r_i_ps) * 60'(r_lc[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage K: output register.
    // ------------------------------------------------------------------
    logic [2:0][15:0] w_spec;
    t_out             r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_spec[i] = r_j_on ? sat16(r_j_psc[i][59:20]) : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.amb_red_out    <= r_amb[0];
        r_out.amb_green_out  <= r_amb[1];
        r_out.amb_blue_out   <= r_amb[2];
        r_out.diff_red_out   <= r_j_sd.diff[0];
        r_out.diff_green_out <= r_j_sd.diff[1];
        r_out.diff_blue_out  <= r_j_sd.diff[2];
        r_out.spec_red_out   <= w_spec[0];
        r_out.spec_green_out <= w_spec[1];
        r_out.spec_blue_out  <= w_spec[2];
    end

    assign o_out   = r_out;
    assign o_valid = r_vld[LAT-1];

endmodule
